// ===== hdl/mlv_pkg.sv =====
// Package for the mean-of-lowest-values block: widths, queue sizing, item type.
// Used by every module under hdl; depends on nothing else.
`default_nettype none

package mlv_pkg;

  localparam int unsigned HEIGHT_W   = 32;
  localparam int unsigned COUNT_W    = 7;
  // 32-bit heights summed over at most 127 entries
  localparam int unsigned SUM_W      = 39;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W     = 2;
  localparam int unsigned QCNT_W     = 3;

  localparam logic [COUNT_W-1:0] LOWEST_COUNT_RESET = 7'd16;

  typedef enum logic [1:0] {
    OP_INSERT       = 2'd0,
    OP_CLOSE        = 2'd1,
    OP_INSERT_CLOSE = 2'd2
  } op_e;

  typedef struct packed {
    op_e                         op;
    logic signed [HEIGHT_W-1:0]  height;
  } item_t;

endpackage

`default_nettype wire

// ===== hdl/mlv_front.sv =====
// Front end: takes command words, drops empty items and tags each word with its op.
// Depends on mlv_pkg.
`default_nettype none

module mlv_front
  import mlv_pkg::*;
(
  input  wire logic                       start_i,
  input  wire logic                       busy_i,
  input  wire logic signed [HEIGHT_W-1:0] height_value_i,
  input  wire logic                       has_point_i,
  input  wire logic                       last_point_i,
  output logic                            push_o,
  output item_t                           item_o
);

  logic accept;

  assign accept = start_i && !busy_i;

  always_comb begin
    item_o.height = height_value_i;
    unique case ({has_point_i, last_point_i})
      2'b10:   item_o.op = OP_INSERT;
      2'b01:   item_o.op = OP_CLOSE;
      2'b11:   item_o.op = OP_INSERT_CLOSE;
      default: item_o.op = OP_INSERT;
    endcase
  end

  // drop a word that carries neither a point nor the end mark
  assign push_o = accept && (has_point_i || last_point_i);

endmodule

`default_nettype wire

// ===== hdl/mlv_queue.sv =====
// Short FIFO of classified words between the front end and the back end.
// Depends on mlv_pkg.
`default_nettype none

module mlv_queue
  import mlv_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t item_i,
  input  wire logic  pop_i,
  output logic       full_o,
  output logic       empty_o,
  output item_t      head_o
);

  item_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]  count_q;
  logic               do_push, do_pop;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mlv_div.sv =====
// Signed divider, one quotient bit per cycle: sum over a 7-bit count, truncated to zero.
// Depends on mlv_pkg.
`default_nettype none

module mlv_div
  import mlv_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic signed [SUM_W-1:0]    dividend_i,
  input  wire logic [COUNT_W-1:0]         divisor_i,
  output logic                            done_o,
  output logic signed [HEIGHT_W-1:0]      quotient_o
);

  localparam int unsigned DCNT_W = $clog2(SUM_W + 1);

  logic                 busy_q, done_q, neg_q;
  logic [DCNT_W-1:0]    cnt_q;
  logic [COUNT_W-1:0]   rem_q;
  logic [SUM_W-1:0]     quo_q;
  logic [COUNT_W-1:0]   dvs_q;
  logic [SUM_W-1:0]     mag;
  logic [COUNT_W:0]     rem_sh;
  logic                 ge;
  logic [HEIGHT_W-1:0]  quo_lo;

  assign mag    = dividend_i[SUM_W-1] ? SUM_W'(-dividend_i) : SUM_W'(dividend_i);
  assign rem_sh = {rem_q, quo_q[SUM_W-1]};
  assign ge     = (rem_sh >= {1'b0, dvs_q});
  assign quo_lo = quo_q[HEIGHT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q <= '0;
        dvs_q <= divisor_i;
        cnt_q <= DCNT_W'(SUM_W);
        if (divisor_i == '0) begin
          // no heights used: report zero at once
          quo_q  <= '0;
          neg_q  <= 1'b0;
          done_q <= 1'b1;
        end else begin
          quo_q  <= mag;
          neg_q  <= dividend_i[SUM_W-1];
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        // remainder stays below the divisor, so it fits the count width
        rem_q <= ge ? COUNT_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[COUNT_W-1:0];
        quo_q <= {quo_q[SUM_W-2:0], ge};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DCNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? -quo_lo : quo_lo;

endmodule

`default_nettype wire

// ===== hdl/mlv_back.sv =====
// Back end: sorted store of the lowest heights, drain-and-sum on close, then divide.
// Depends on mlv_pkg and mlv_div.
`default_nettype none

module mlv_back
  import mlv_pkg::*;
#(
  parameter int unsigned MAX_LOWEST = 64
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [COUNT_W-1:0]         lowest_count_i,
  input  wire logic                       empty_i,
  input  wire item_t                      head_i,
  output logic                            pop_o,
  output logic                            done_o,
  output logic signed [HEIGHT_W-1:0]      mean_height_o,
  output logic [COUNT_W-1:0]              used_count_o
);

  localparam int unsigned KW = $clog2(MAX_LOWEST + 1);
  localparam int unsigned CW = (KW > COUNT_W) ? KW : COUNT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLOSE,
    ST_DRAIN,
    ST_DIV
  } state_e;

  state_e                       state_q;
  logic signed [HEIGHT_W-1:0]   cell_q   [MAX_LOWEST];
  logic signed [HEIGHT_W-1:0]   ins_cell [MAX_LOWEST];
  logic signed [HEIGHT_W-1:0]   shf_cell [MAX_LOWEST];
  logic [MAX_LOWEST-1:0]        above;
  logic [KW-1:0]                kept_q, kept_eff;
  logic                         full, drop, is_ins, is_close, do_ins;
  logic [COUNT_W-1:0]           used_q, cnt_q, used_w;
  logic [CW-1:0]                lc_ext, kept_ext, max_ext, min_a;
  logic signed [SUM_W-1:0]      acc_q;
  logic signed [HEIGHT_W-1:0]   mean_q;
  logic                         done_q;
  logic                         div_start, div_done;
  logic signed [HEIGHT_W-1:0]   div_quo;

  always_comb begin
    unique case (head_i.op)
      OP_INSERT:       begin is_ins = 1'b1; is_close = 1'b0; end
      OP_CLOSE:        begin is_ins = 1'b0; is_close = 1'b1; end
      OP_INSERT_CLOSE: begin is_ins = 1'b1; is_close = 1'b1; end
      default:         begin is_ins = 1'b0; is_close = 1'b0; end
    endcase
  end

  assign pop_o    = (state_q == ST_IDLE) && !empty_i;
  assign full     = (kept_q == KW'(MAX_LOWEST));
  assign drop     = full && (head_i.height >= cell_q[MAX_LOWEST-1]);
  assign kept_eff = full ? KW'(MAX_LOWEST - 1) : kept_q;
  assign do_ins   = pop_o && is_ins && !drop;

  // parallel compare: entries above the new height move up one place
  always_comb begin
    for (int i = 0; i < MAX_LOWEST; i++) begin
      above[i] = (KW'(i) < kept_eff) && (cell_q[i] > head_i.height);
    end
    ins_cell[0] = (above[0] || kept_eff == '0) ? head_i.height : cell_q[0];
    for (int i = 1; i < MAX_LOWEST; i++) begin
      if (above[i-1]) begin
        ins_cell[i] = cell_q[i-1];
      end else if (above[i] || kept_eff == KW'(i)) begin
        ins_cell[i] = head_i.height;
      end else begin
        ins_cell[i] = cell_q[i];
      end
    end
  end

  // drain: advance the store toward entry zero
  always_comb begin
    for (int i = 0; i < MAX_LOWEST - 1; i++) begin
      shf_cell[i] = cell_q[i+1];
    end
    shf_cell[MAX_LOWEST-1] = cell_q[MAX_LOWEST-1];
  end

  always_comb begin
    lc_ext   = CW'(lowest_count_i);
    kept_ext = CW'(kept_q);
    max_ext  = CW'(MAX_LOWEST);
    min_a    = (lc_ext < max_ext) ? lc_ext : max_ext;
    min_a    = (min_a < kept_ext) ? min_a : kept_ext;
    used_w   = min_a[COUNT_W-1:0];
  end

  assign div_start = (state_q == ST_DRAIN) && (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (do_ins) begin
      cell_q <= ins_cell;
    end else if (state_q == ST_DRAIN && cnt_q != '0) begin
      cell_q <= shf_cell;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kept_q  <= '0;
      used_q  <= '0;
      cnt_q   <= '0;
      acc_q   <= '0;
      mean_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (do_ins) begin
            kept_q <= KW'(kept_eff + 1'b1);
          end
          if (pop_o && is_close) begin
            state_q <= ST_CLOSE;
          end
        end
        ST_CLOSE: begin
          used_q  <= used_w;
          cnt_q   <= used_w;
          acc_q   <= '0;
          kept_q  <= '0;
          state_q <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (cnt_q != '0) begin
            acc_q <= acc_q + {{(SUM_W-HEIGHT_W){cell_q[0][HEIGHT_W-1]}}, cell_q[0]};
            cnt_q <= cnt_q - 1'b1;
          end else begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            mean_q  <= div_quo;
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  mlv_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_q),
    .divisor_i  (used_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign done_o        = done_q;
  assign mean_height_o = mean_q;
  assign used_count_o  = used_q;

`ifndef SYNTH
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe held longer than one cycle");

  a_kept_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_q <= KW'(MAX_LOWEST))
    else $error("kept count beyond store depth");

  a_close_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLOSE |=> (kept_q == '0) && (state_q == ST_DRAIN))
    else $error("store not emptied on close");

  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide phase");
`endif

endmodule

`default_nettype wire

// ===== hdl/mean_of_lowest_values.sv =====
// Top level: mean of the lowest point heights of a cloud.
// Depends on mlv_pkg, mlv_front, mlv_queue, mlv_back (which holds mlv_div).
//
//  channel   | ports                                           | flow
//  ----------+-------------------------------------------------+---------------------
//  command   | start, busy, height_value_i, has_point_i,       | taken when start & !busy
//            | last_point_i                                    |
//  result    | done_o, mean_height_o, used_count_o             | one-cycle strobe
//  config    | cfg_valid_i, cfg_ready_o, cfg_data_i            | valid & ready
//
// A point word is sorted into the store as it is popped; a closing word drains
// the averaged heights from the sorted store into a sum, then the 39-bit divider
// produces one quotient bit per cycle. No word is popped until the result is out.
// A four-word queue decouples the command side; busy is high while it is full.
// Reset clears the queue, the kept count and the configured count (back to 16).
// Results cannot be held off; each is shown for exactly one cycle.
`default_nettype none

module mean_of_lowest_values
  import mlv_pkg::*;
#(
  parameter int unsigned MAX_LOWEST = 64
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic signed [HEIGHT_W-1:0] height_value_i,
  input  wire logic                       has_point_i,
  input  wire logic                       last_point_i,
  output logic                            done_o,
  output logic signed [HEIGHT_W-1:0]      mean_height_o,
  output logic [COUNT_W-1:0]              used_count_o,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [COUNT_W-1:0]         cfg_data_i
);

  logic [COUNT_W-1:0] lowest_count_q;
  logic               push, pop, q_full, q_empty;
  item_t              push_item, head_item;

  assign cfg_ready_o = 1'b1;
  assign busy        = q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lowest_count_q <= LOWEST_COUNT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      lowest_count_q <= cfg_data_i;
    end
  end

  mlv_front u_front (
    .start_i        (start),
    .busy_i         (q_full),
    .height_value_i (height_value_i),
    .has_point_i    (has_point_i),
    .last_point_i   (last_point_i),
    .push_o         (push),
    .item_o         (push_item)
  );

  mlv_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (head_item)
  );

  mlv_back #(
    .MAX_LOWEST (MAX_LOWEST)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .lowest_count_i (lowest_count_q),
    .empty_i        (q_empty),
    .head_i         (head_item),
    .pop_o          (pop),
    .done_o         (done_o),
    .mean_height_o  (mean_height_o),
    .used_count_o   (used_count_o)
  );

endmodule

`default_nettype wire
